[hw/rtl/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the free-list pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  // operation codes carried by the mode field
  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_PUSH  = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_POOL_EMPTY = 2'd1,
    STAT_NULL_FREED = 2'd2,
    STAT_BAD_INDEX  = 2'd3
  } status_t;

  localparam int VALUE_W = 64;

  // value word held by every entry after reset
  localparam logic signed [VALUE_W-1:0] RESET_WORD = -64'sd42;

endpackage : pfa_pkg

`default_nettype wire

[hw/rtl/pfa_req_if.sv]
// ----------------------------------------------------------------------------
// pfa_req_if
// Request channel of the allocator: one operation per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfa_req_if #(
  parameter int IDX_W = 6
);
  logic                                  valid;
  logic                                  ready;
  pfa_pkg::mode_t                        mode;
  logic signed [pfa_pkg::VALUE_W-1:0]    value;
  logic        [IDX_W-1:0]               list_head;

  modport source (output valid, output mode, output value, output list_head, input ready);
  modport sink   (input valid, input mode, input value, input list_head, output ready);
endinterface : pfa_req_if

`default_nettype wire

[hw/rtl/pfa_rsp_if.sv]
// ----------------------------------------------------------------------------
// pfa_rsp_if
// Response channel of the allocator: one result item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfa_rsp_if #(
  parameter int IDX_W = 6
);
  logic                                  valid;
  logic                                  ready;
  logic        [IDX_W-1:0]               index;
  logic signed [pfa_pkg::VALUE_W-1:0]    entry_value;
  logic        [IDX_W-1:0]               entry_next;
  pfa_pkg::status_t                      status;

  modport source (output valid, output index, output entry_value, output entry_next,
                  output status, input ready);
  modport sink   (input valid, input index, input entry_value, input entry_next,
                  input status, output ready);
endinterface : pfa_rsp_if

`default_nettype wire

[hw/rtl/pool_free_list_allocator_core.sv]
// ----------------------------------------------------------------------------
// pool_free_list_allocator_core
// Fixed pool of linked entries with a free list: alloc, push front, free
// front and entry read, backed by a link memory and a value memory.
// ----------------------------------------------------------------------------
// Each request is handled in an accept step and an execute step: the
// accept edge issues one read of the link and value memories (synchronous,
// registered read data) at the free head or the given entry, and the execute
// step uses the read data to write the entry back, move the free head and
// load the result register. A new request is accepted only once the previous
// one has left its execute step; a waiting result holds the block in its
// execute step. After reset a clearing pass over all POOL_ENTRIES entries
// chains every entry into the free list and loads the reset value word; no
// request is accepted until it ends. Index POOL_ENTRIES+1 is the null marker.
`default_nettype none

module pool_free_list_allocator_core #(
  parameter int POOL_ENTRIES = 32
) (
  input  wire       clk,
  input  wire       rst,
  pfa_req_if.sink   req,
  pfa_rsp_if.source rsp
);

  localparam int ADDR_W = $clog2(POOL_ENTRIES);
  localparam int IDX_W  = $clog2(POOL_ENTRIES + 2);
  localparam int VAL_W  = pfa_pkg::VALUE_W;

  localparam logic [IDX_W-1:0]  NULL_IDX  = IDX_W'(POOL_ENTRIES + 1);
  localparam logic [IDX_W-1:0]  ENTRY_LIM = IDX_W'(POOL_ENTRIES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // memories
  logic        [IDX_W-1:0] link_mem  [POOL_ENTRIES];
  logic signed [VAL_W-1:0] value_mem [POOL_ENTRIES];
  logic        [IDX_W-1:0] link_rd;
  logic signed [VAL_W-1:0] value_rd;

  // control and latched request
  logic        [ADDR_W-1:0] clr_addr;
  logic        [IDX_W-1:0]  free_head;
  logic        [IDX_W-1:0]  free_head_next;
  pfa_pkg::mode_t           op_mode;
  logic signed [VAL_W-1:0]  op_value;
  logic        [IDX_W-1:0]  op_head;

  // result register
  logic                     out_valid;
  logic        [IDX_W-1:0]  out_index;
  logic signed [VAL_W-1:0]  out_entry_value;
  logic        [IDX_W-1:0]  out_entry_next;
  pfa_pkg::status_t         out_status;

  // execute step results
  logic        [IDX_W-1:0]  res_index;
  logic signed [VAL_W-1:0]  res_entry_value;
  logic        [IDX_W-1:0]  res_entry_next;
  pfa_pkg::status_t         res_status;
  logic                     ex_link_we;
  logic                     ex_value_we;
  logic        [ADDR_W-1:0] ex_addr;
  logic        [IDX_W-1:0]  ex_link;

  // memory port signals
  logic                     accept;
  logic                     exec_go;
  logic        [ADDR_W-1:0] rd_addr;
  logic                     link_we;
  logic                     value_we;
  logic        [ADDR_W-1:0] wr_addr;
  logic        [IDX_W-1:0]  wr_link;
  logic signed [VAL_W-1:0]  wr_value;

  logic head_is_entry;
  logic head_is_null;
  logic pool_empty;

  // handshake
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign exec_go   = (state == ST_EXEC) && (!out_valid || rsp.ready);

  assign rsp.valid       = out_valid;
  assign rsp.index       = out_index;
  assign rsp.entry_value = out_entry_value;
  assign rsp.entry_next  = out_entry_next;
  assign rsp.status      = out_status;

  // read address: free head for pops, the given entry otherwise
  always_comb begin
    if (req.mode == pfa_pkg::MODE_ALLOC || req.mode == pfa_pkg::MODE_PUSH) begin
      rd_addr = free_head[ADDR_W-1:0];
    end else begin
      rd_addr = req.list_head[ADDR_W-1:0];
    end
  end

  // execute step: decide result and write-back from the read data
  assign head_is_entry = (op_head < ENTRY_LIM);
  assign head_is_null  = (op_head == NULL_IDX);
  assign pool_empty    = !(free_head < ENTRY_LIM);

  always_comb begin
    res_index       = NULL_IDX;
    res_entry_value = '0;
    res_entry_next  = NULL_IDX;
    res_status      = pfa_pkg::STAT_OK;
    ex_link_we      = 1'b0;
    ex_value_we     = 1'b0;
    ex_addr         = free_head[ADDR_W-1:0];
    ex_link         = NULL_IDX;
    free_head_next  = free_head;
    unique case (op_mode)
      pfa_pkg::MODE_ALLOC, pfa_pkg::MODE_PUSH: begin
        if (op_mode == pfa_pkg::MODE_PUSH && !head_is_entry && !head_is_null) begin
          res_status = pfa_pkg::STAT_BAD_INDEX;
        end else if (pool_empty) begin
          res_status = pfa_pkg::STAT_POOL_EMPTY;
        end else begin
          ex_link_we     = 1'b1;
          ex_value_we    = 1'b1;
          ex_link        = (op_mode == pfa_pkg::MODE_PUSH) ? op_head : NULL_IDX;
          free_head_next = link_rd;
          res_index      = free_head;
        end
      end
      pfa_pkg::MODE_FREE: begin
        if (head_is_null) begin
          res_status = pfa_pkg::STAT_NULL_FREED;
        end else if (!head_is_entry) begin
          res_status = pfa_pkg::STAT_BAD_INDEX;
        end else begin
          ex_link_we     = 1'b1;
          ex_addr        = op_head[ADDR_W-1:0];
          ex_link        = free_head;
          free_head_next = op_head;
          res_index      = link_rd;
        end
      end
      pfa_pkg::MODE_READ: begin
        if (!head_is_entry) begin
          res_status = pfa_pkg::STAT_BAD_INDEX;
        end else begin
          res_entry_value = value_rd;
          res_entry_next  = link_rd;
        end
      end
      default: begin
        res_status = pfa_pkg::STAT_BAD_INDEX;
      end
    endcase
  end

  // write port: clearing pass or execute step
  always_comb begin
    if (state == ST_CLEAR) begin
      link_we  = 1'b1;
      value_we = 1'b1;
      wr_addr  = clr_addr;
      wr_link  = (clr_addr == LAST_ADDR) ? NULL_IDX : (IDX_W'(clr_addr) + IDX_W'(1));
      wr_value = pfa_pkg::RESET_WORD;
    end else begin
      link_we  = exec_go && ex_link_we;
      value_we = exec_go && ex_value_we;
      wr_addr  = ex_addr;
      wr_link  = ex_link;
      wr_value = op_value;
    end
  end

  // link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
    if (accept) begin
      link_rd <= link_mem[rd_addr];
    end
  end

  // value memory
  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[wr_addr] <= wr_value;
    end
    if (accept) begin
      value_rd <= value_mem[rd_addr];
    end
  end

  // sequencer, free head and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      free_head <= '0;
      out_valid <= 1'b0;
    end else begin
      // result drained with no new one loaded behind it
      if (out_valid && rsp.ready && !exec_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_mode  <= req.mode;
            op_value <= req.value;
            op_head  <= req.list_head;
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            free_head       <= free_head_next;
            out_valid       <= 1'b1;
            out_index       <= res_index;
            out_entry_value <= res_entry_value;
            out_entry_next  <= res_entry_next;
            out_status      <= res_status;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule : pool_free_list_allocator_core

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the free-list pool allocator core. A planning copy
// of the pool builds directed and random operation items, a second copy
// follows accepted items and predicts each result. The sender runs in
// bursts, the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
  import pfa_pkg::*;

  localparam int POOL_ENTRIES = 32;
  localparam int IDX_W        = 6;
  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(POOL_ENTRIES + 1);
  localparam int RANDOM_ITEMS = 1530;
  localparam int DRAIN_EVERY  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_PRINTS   = 100;

  typedef struct packed {
    logic               hold;       // wait for every result before sending
    mode_t              mode;
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   list_head;
  } pool_op_t;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [VALUE_W-1:0] entry_value;
    logic [IDX_W-1:0]   entry_next;
    status_t            status;
  } pool_rsp_t;

  typedef struct packed {
    logic [IDX_W-1:0]                     free_head;
    logic [POOL_ENTRIES-1:0][IDX_W-1:0]   link;
    logic [POOL_ENTRIES-1:0][VALUE_W-1:0] word;
  } pool_state_t;

  logic clk;
  logic rst;

  pfa_req_if #(.IDX_W(IDX_W)) req_ch ();
  pfa_rsp_if #(.IDX_W(IDX_W)) rsp_ch ();

  pool_free_list_allocator_core #(.POOL_ENTRIES(POOL_ENTRIES)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  pool_op_t         ops_to_send[$];
  pool_rsp_t        results_due[$];
  pool_state_t      plan_pool;
  pool_state_t      live_pool;
  logic [IDX_W-1:0] list_heads[$];
  pool_rsp_t        want;
  int               err_cnt = 0;
  int               idle_cycles = 0;
  int               burst_left;
  int               gap_left;
  int               stall_mode;
  int               mode_left;
  int               stall_left;

  function automatic bit is_entry(logic [IDX_W-1:0] i);
    return i < POOL_ENTRIES;
  endfunction

  // every entry chained into the free list, value word at its reset value
  function automatic pool_state_t pool_after_reset();
    pool_state_t p;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      p.link[i] = IDX_W'(i + 1);
      p.word[i] = RESET_WORD;
    end
    p.link[POOL_ENTRIES-1] = NULL_IDX;
    p.free_head = '0;
    return p;
  endfunction

  // one operation on the pool: updates the state, returns the result item
  function automatic pool_rsp_t apply_pool_op(inout pool_state_t p, input pool_op_t op);
    pool_rsp_t        res;
    logic [IDX_W-1:0] slot;
    res.index       = NULL_IDX;
    res.entry_value = '0;
    res.entry_next  = NULL_IDX;
    res.status      = STAT_OK;
    slot            = op.list_head;
    case (op.mode)
      MODE_ALLOC, MODE_PUSH: begin
        if (op.mode == MODE_PUSH && !is_entry(op.list_head) && op.list_head != NULL_IDX) begin
          res.status = STAT_BAD_INDEX;
        end else if (!is_entry(p.free_head)) begin
          res.status = STAT_POOL_EMPTY;
        end else begin
          slot = p.free_head;
          p.free_head = p.link[slot];
          p.link[slot] = (op.mode == MODE_PUSH) ? op.list_head : NULL_IDX;
          p.word[slot] = op.value;
          res.index = slot;
        end
      end
      MODE_FREE: begin
        if (op.list_head == NULL_IDX) begin
          res.status = STAT_NULL_FREED;
        end else if (!is_entry(op.list_head)) begin
          res.status = STAT_BAD_INDEX;
        end else begin
          res.index = p.link[slot];
          p.link[slot] = p.free_head;
          p.free_head = slot;
        end
      end
      default: begin
        if (!is_entry(op.list_head)) begin
          res.status = STAT_BAD_INDEX;
        end else begin
          res.entry_value = p.word[slot];
          res.entry_next = p.link[slot];
        end
      end
    endcase
    return res;
  endfunction

  // data word, with the extremes mixed in
  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(VALUE_W-1){1'b1}}};
      1: return {1'b1, {(VALUE_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // index that is neither an entry nor the null marker
  function automatic logic [IDX_W-1:0] bad_index();
    int i;
    i = $urandom_range(POOL_ENTRIES, 2**IDX_W - 2);
    if (i >= NULL_IDX) i++;
    return IDX_W'(i);
  endfunction

  // queue one item and advance the planning pool
  function automatic pool_rsp_t plan_item(mode_t m, logic [VALUE_W-1:0] v,
                                          logic [IDX_W-1:0] h, logic hold = 1'b0);
    pool_op_t op;
    op.hold      = hold;
    op.mode      = m;
    op.value     = v;
    op.list_head = h;
    ops_to_send.insert(ops_to_send.size(), op);
    return apply_pool_op(plan_pool, op);
  endfunction

  // one random item: mostly operations on lists built so far, some noise
  task automatic plan_random(input bit grow, input logic hold);
    pool_rsp_t res;
    int        pick;
    int        k;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      case ($urandom_range(0, 5))
        0: res = plan_item(MODE_FREE, pick_word(), NULL_IDX, hold);
        1: res = plan_item(MODE_FREE, pick_word(), bad_index(), hold);
        2: res = plan_item(MODE_PUSH, pick_word(), bad_index(), hold);
        3: res = plan_item(MODE_READ, pick_word(),
                           ($urandom_range(0, 3) == 0) ? NULL_IDX : bad_index(), hold);
        // may free an entry that is already free
        4: res = plan_item(MODE_FREE, pick_word(),
                           IDX_W'($urandom_range(0, POOL_ENTRIES - 1)), hold);
        default: begin
          res = plan_item(MODE_ALLOC, pick_word(), IDX_W'($urandom), hold);
          if (res.status == STAT_OK) list_heads.insert(list_heads.size(), res.index);
        end
      endcase
    end else if (pick < (grow ? 30 : 10)) begin
      res = plan_item(MODE_ALLOC, pick_word(), IDX_W'($urandom), hold);
      if (res.status == STAT_OK) list_heads.insert(list_heads.size(), res.index);
    end else if (pick < (grow ? 65 : 20)) begin
      if (list_heads.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, list_heads.size() - 1);
        res = plan_item(MODE_PUSH, pick_word(), list_heads[k], hold);
        if (res.status == STAT_OK) list_heads[k] = res.index;
      end else begin
        res = plan_item(MODE_PUSH, pick_word(), NULL_IDX, hold);
        if (res.status == STAT_OK) list_heads.insert(list_heads.size(), res.index);
      end
    end else if (pick < (grow ? 85 : 80)) begin
      if (list_heads.size() > 0) begin
        k = $urandom_range(0, list_heads.size() - 1);
        res = plan_item(MODE_FREE, pick_word(), list_heads[k], hold);
        if (!is_entry(res.index)) list_heads.delete(k);
        else list_heads[k] = res.index;
      end else begin
        res = plan_item(MODE_FREE, pick_word(), NULL_IDX, hold);
      end
    end else begin
      if (list_heads.size() > 0 && $urandom_range(0, 2) == 0) begin
        k = $urandom_range(0, list_heads.size() - 1);
        res = plan_item(MODE_READ, pick_word(), list_heads[k], hold);
      end else begin
        res = plan_item(MODE_READ, pick_word(), IDX_W'($urandom_range(0, POOL_ENTRIES - 1)),
                        hold);
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    if (err_cnt < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
    err_cnt++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        results_due.insert(results_due.size(),
                           apply_pool_op(live_pool, ops_to_send.pop_front()));
      end
      if (req_ch.valid && !req_ch.ready) begin
        // item still offered, hold it
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (ops_to_send.size() > 0 &&
                   !(ops_to_send[0].hold && results_due.size() > 0)) begin
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= ops_to_send[0].mode;
        req_ch.value     <= ops_to_send[0].value;
        req_ch.list_head <= ops_to_send[0].list_head;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_mode = 0;
      mode_left = 0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = results_due.pop_front();
          if (rsp_ch.index !== want.index)
            report_mismatch($sformatf("index got %0d want %0d", rsp_ch.index, want.index));
          if (rsp_ch.entry_value !== want.entry_value)
            report_mismatch($sformatf("entry_value got %h want %h",
                                      rsp_ch.entry_value, want.entry_value));
          if (rsp_ch.entry_next !== want.entry_next)
            report_mismatch($sformatf("entry_next got %0d want %0d",
                                      rsp_ch.entry_next, want.entry_next));
          if (rsp_ch.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp_ch.status, want.status));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
          end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 16);
          end
        end
      endcase
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus plan, reset and end of run
  initial begin
    pool_rsp_t ra;
    pool_rsp_t rb;
    pool_rsp_t rc;
    pool_rsp_t rd;
    bit        grow;
    req_ch.valid     = 1'b0;
    req_ch.mode      = MODE_ALLOC;
    req_ch.value     = '0;
    req_ch.list_head = '0;
    rsp_ch.ready     = 1'b0;
    rst              = 1'b1;
    plan_pool = pool_after_reset();
    live_pool = pool_after_reset();

    // reads of the pool as reset left it, then bad and null read indexes
    void'(plan_item(MODE_READ, '0, 6'd0));
    void'(plan_item(MODE_READ, '0, IDX_W'(POOL_ENTRIES - 1)));
    void'(plan_item(MODE_READ, '1, IDX_W'(POOL_ENTRIES)));
    void'(plan_item(MODE_READ, '0, NULL_IDX));
    void'(plan_item(MODE_READ, '0, '1));
    // alloc with the word extremes, push onto a null list and onto a list
    ra = plan_item(MODE_ALLOC, {1'b0, {(VALUE_W-1){1'b1}}}, '1);
    rb = plan_item(MODE_ALLOC, {1'b1, {(VALUE_W-1){1'b0}}}, '0);
    rc = plan_item(MODE_PUSH, '0, NULL_IDX);
    rd = plan_item(MODE_PUSH, '1, rc.index);
    // bad push heads, null list freed, bad free indexes
    void'(plan_item(MODE_PUSH, 64'h0123_4567_89ab_cdef, IDX_W'(POOL_ENTRIES + 2)));
    void'(plan_item(MODE_PUSH, 64'h0123_4567_89ab_cdef, '1));
    void'(plan_item(MODE_FREE, '0, NULL_IDX));
    void'(plan_item(MODE_FREE, '0, IDX_W'(POOL_ENTRIES)));
    void'(plan_item(MODE_FREE, '0, 6'd62));
    // walk and free the two-entry list front first
    void'(plan_item(MODE_READ, '0, rd.index));
    void'(plan_item(MODE_FREE, '0, rd.index));
    void'(plan_item(MODE_FREE, '0, rc.index));
    void'(plan_item(MODE_READ, '0, ra.index));
    void'(plan_item(MODE_READ, '0, rb.index));
    void'(plan_item(MODE_FREE, '0, ra.index));
    rc = plan_item(MODE_PUSH, 64'h5555_5555_5555_5555, rb.index);
    void'(plan_item(MODE_READ, '0, rc.index));
    list_heads.insert(list_heads.size(), rc.index);
    // double free of the free-list tail turns the free list into a ring
    void'(plan_item(MODE_FREE, 64'haaaa_aaaa_aaaa_aaaa, IDX_W'(POOL_ENTRIES - 1)));

    // random part: grow until the pool runs dry, then shrink, and so on
    grow = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      plan_random(grow, (n % DRAIN_EVERY) == 0);
      if (grow && (!is_entry(plan_pool.free_head) && $urandom_range(0, 3) == 0 ||
                   $urandom_range(0, 300) == 0)) begin
        grow = 1'b0;
      end else if (!grow && (list_heads.size() == 0 || $urandom_range(0, 120) == 0)) begin
        grow = 1'b1;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (ops_to_send.size() != 0 || req_ch.valid || results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule : tb
